[rtl/bbc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and character decode for the bracket balance checker.
// No dependencies.
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CH_OPEN_ANGLE  = 8'h3C;
    localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

    typedef logic [1:0] t_code;

    localparam t_code CODE_PAREN  = 2'd0;
    localparam t_code CODE_BRACE  = 2'd1;
    localparam t_code CODE_ANGLE  = 2'd2;
    localparam t_code CODE_SQUARE = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } t_stack_op;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MISMATCH = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_OVERFLOW = 3'd4
    } t_err;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        t_code code;
    } t_bracket;

    function automatic t_bracket decode_char(input logic [7:0] c);
        t_bracket b;
        b = '{is_open: 1'b0, is_close: 1'b0, code: CODE_PAREN};
        unique case (c)
            CH_OPEN_PAREN:   b = '{is_open: 1'b1, is_close: 1'b0, code: CODE_PAREN};
            CH_OPEN_BRACE:   b = '{is_open: 1'b1, is_close: 1'b0, code: CODE_BRACE};
            CH_OPEN_ANGLE:   b = '{is_open: 1'b1, is_close: 1'b0, code: CODE_ANGLE};
            CH_OPEN_SQUARE:  b = '{is_open: 1'b1, is_close: 1'b0, code: CODE_SQUARE};
            CH_CLOSE_PAREN:  b = '{is_open: 1'b0, is_close: 1'b1, code: CODE_PAREN};
            CH_CLOSE_BRACE:  b = '{is_open: 1'b0, is_close: 1'b1, code: CODE_BRACE};
            CH_CLOSE_ANGLE:  b = '{is_open: 1'b0, is_close: 1'b1, code: CODE_ANGLE};
            CH_CLOSE_SQUARE: b = '{is_open: 1'b0, is_close: 1'b1, code: CODE_SQUARE};
            default:         b = '{is_open: 1'b0, is_close: 1'b0, code: CODE_PAREN};
        endcase
        return b;
    endfunction

endpackage

[rtl/bbc_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the character input and the result output.
// No dependencies.
interface bbc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface bbc_res_if;
    logic       valid;
    logic       ready;
    logic       balanced;
    logic [2:0] error_kind;

    modport source (output valid, output balanced, output error_kind, input ready);
    modport sink   (input valid, input balanced, input error_kind, output ready);
endinterface

[rtl/bbc_cell.sv]
`timescale 1ns / 1ps
// One stack cell: holds a bracket type code and shifts with its neighbors.
// Depends on bbc_pkg.
module bbc_cell
    import bbc_pkg::*;
(
    input  logic      i_clk,
    input  t_stack_op i_op,
    input  t_code     i_from_up,
    input  t_code     i_from_down,
    output t_code     o_code
);

    t_code r_code;
    t_code n_code;

    always_comb begin
        unique case (i_op)
            OP_PUSH: n_code = i_from_up;
            OP_POP:  n_code = i_from_down;
            default: n_code = r_code;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

[rtl/bbc_stack.sv]
`timescale 1ns / 1ps
// Shift-register stack built as a row of bbc_cell; cell 0 is the top.
// Depends on bbc_pkg and bbc_cell.
module bbc_stack
    import bbc_pkg::*;
(
    input  logic      i_clk,
    input  t_stack_op i_op,
    input  t_code     i_push_code,
    output t_code     o_top_code
);

    t_code w_code [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_code w_up;
        t_code w_down;

        if (g == 0) begin : g_top
            assign w_up = i_push_code;
        end else begin : g_mid_up
            assign w_up = w_code[g-1];
        end

        // the bottom cell refills with don't-care data on a pop
        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign w_down = CODE_PAREN;
        end else begin : g_mid_down
            assign w_down = w_code[g+1];
        end

        bbc_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (i_op),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_code      (w_code[g])
        );
    end

    assign o_top_code = w_code[0];

endmodule

[rtl/bracket_balance_checker.sv]
`timescale 1ns / 1ps
// Bracket balance checker: one character per beat, one result per string.
// 1 character per cycle unless a pending result stalls input; at most one push or pop per beat.
// The result is registered and appears in the cycle after the beat with last_char set.
// Reset clears depth, sticky error and output valid; stack cells are not reset.
// Depends on bbc_pkg, bbc_if, bbc_stack.
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    bbc_char_if.sink   i_char_if,
    bbc_res_if.source  o_res_if
);

    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    t_err               r_err;
    t_err               n_err;
    logic               r_out_valid;
    logic               r_balanced;
    t_err               r_kind;
    t_err               w_kind;

    t_stack_op w_op;
    t_code     w_top;
    t_bracket  w_dec;
    logic      w_accept;
    logic      w_full;
    logic      w_empty;

    assign i_char_if.ready = !r_out_valid || o_res_if.ready;
    assign w_accept        = i_char_if.valid && i_char_if.ready;
    assign w_dec           = decode_char(i_char_if.char_code);
    assign w_full          = (r_depth == DEPTH_W'(STACK_DEPTH));
    assign w_empty         = (r_depth == '0);

    bbc_stack u_stack (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_push_code (w_dec.code),
        .o_top_code  (w_top)
    );

    always_comb begin
        n_depth = r_depth;
        n_err   = r_err;
        w_op    = OP_HOLD;
        w_kind  = ERR_NONE;
        if (w_accept) begin
            // brackets are ignored once an error is held
            if (r_err == ERR_NONE) begin
                if (w_dec.is_open) begin
                    if (w_full) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        w_op    = OP_PUSH;
                        n_depth = r_depth + DEPTH_W'(1);
                    end
                end else if (w_dec.is_close) begin
                    if (w_empty) begin
                        n_err = ERR_EMPTY;
                    end else if (w_top != w_dec.code) begin
                        n_err = ERR_MISMATCH;
                    end else begin
                        w_op    = OP_POP;
                        n_depth = r_depth - DEPTH_W'(1);
                    end
                end
            end
            w_kind = n_err;
            if (n_err == ERR_NONE && n_depth != '0) begin
                w_kind = ERR_UNCLOSED;
            end
            if (i_char_if.last_char) begin
                n_depth = '0;
                n_err   = ERR_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_err   <= n_err;
            if (w_accept && i_char_if.last_char) begin
                r_out_valid <= 1'b1;
            end else if (o_res_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load the result beat; the accept condition already implies the slot is free or being emptied
    always_ff @(posedge i_clk) begin
        if (w_accept && i_char_if.last_char) begin
            r_balanced <= (w_kind == ERR_NONE);
            r_kind     <= w_kind;
        end
    end

    assign o_res_if.valid      = r_out_valid;
    assign o_res_if.balanced   = r_balanced;
    assign o_res_if.error_kind = r_kind;

endmodule

[rtl/bbc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for bracket_balance_checker, attached by bind.
// Depends on bbc_pkg.
module bbc_checker
    import bbc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_balanced,
    input logic [2:0] i_error_kind
);

    a_balanced_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_balanced == (i_error_kind == ERR_NONE)))
        else $error("balanced flag disagrees with error kind");

    a_kind_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_error_kind <= ERR_OVERFLOW))
        else $error("error kind out of range");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> i_out_valid)
        else $error("no result after last character");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !$past(i_out_valid && !i_out_ready))
            |-> $past(i_in_valid && i_in_ready && i_in_last))
        else $error("result beat without a last character");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_char_if.valid),
    .i_in_ready   (i_char_if.ready),
    .i_in_last    (i_char_if.last_char),
    .i_out_valid  (o_res_if.valid),
    .i_out_ready  (o_res_if.ready),
    .i_balanced   (o_res_if.balanced),
    .i_error_kind (o_res_if.error_kind)
);
